### rtl/core/ssa_pkg.sv
// ssa_pkg: constants, types and codes shared by the slab allocator
// no dependencies; compiled first

package ssa_pkg;

   localparam int GRAIN_BYTES  = 16;
   localparam int NUM_CLASSES  = 32;
   localparam int CHUNK_BYTES  = 64 * 1024;
   localparam int POOL_BYTES   = 1048576;
   localparam int HEADER_BYTES = 16;

   localparam int NUM_GRAINS    = POOL_BYTES / GRAIN_BYTES;
   localparam int NUM_CHUNKS    = POOL_BYTES / CHUNK_BYTES;
   localparam int CHUNK_GRAINS  = CHUNK_BYTES / GRAIN_BYTES;
   localparam int LARGEST_BYTES = GRAIN_BYTES * NUM_CLASSES;
   // largest block step (in grains) that still fits once past the chunk's first grain
   localparam int MAX_FIT_STEP  = (CHUNK_BYTES - GRAIN_BYTES) / GRAIN_BYTES;

   localparam int GRAIN_SHIFT = $clog2(GRAIN_BYTES);
   localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
   localparam int GRAIN_W     = $clog2(NUM_GRAINS);
   localparam int CHUNK_W     = $clog2(NUM_CHUNKS);
   localparam int CIDX_W      = $clog2(CHUNK_GRAINS);
   localparam int CLS_IDX_W   = $clog2(NUM_CLASSES);
   localparam int OFF_W       = CIDX_W + 2;

   // fixed field widths
   localparam int BYTES_W  = 16;
   localparam int ADDR_W   = 20;
   localparam int CLASS_W  = 5;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERSIZE  = 2'd1,
      ST_EXHAUSTED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_CARVE
   } state_type;

   typedef logic [GRAIN_W-1:0] grain_type;

   typedef struct packed {
      logic      rd_en;
      grain_type rd_addr;
      logic      wr_en;
      grain_type wr_addr;
      grain_type wr_data;
   } link_req_type;

   typedef struct packed {
      logic                load;
      status_type          status;
      logic [ADDR_W-1:0]   addr;
      logic [CLASS_W-1:0]  cls;
   } rsp_load_type;

endpackage

### rtl/core/ssa_chan_if.sv
// ssa_chan_if: valid/ready channel interfaces for request and response words
// depends on ssa_pkg

interface ssa_req_if;
   import ssa_pkg::*;
   logic               valid;
   logic               ready;
   opcode_type         opcode;
   logic [BYTES_W-1:0] request_bytes;
   logic [ADDR_W-1:0]  block_address;
   modport source(output valid, opcode, request_bytes, block_address, input ready);
   modport sink(input valid, opcode, request_bytes, block_address, output ready);
endinterface

interface ssa_rsp_if;
   import ssa_pkg::*;
   logic               valid;
   logic               ready;
   status_type         status;
   logic [ADDR_W-1:0]  granted_address;
   logic [CLASS_W-1:0] size_class;
   modport source(output valid, status, granted_address, size_class, input ready);
   modport sink(input valid, status, granted_address, size_class, output ready);
endinterface

### rtl/core/ssa_link_ram.sv
// ssa_link_ram: free-list link memory, one write and one registered read port
// depends on ssa_pkg

module ssa_link_ram (
   input  logic                  clock,
   input  ssa_pkg::link_req_type link_req,
   output ssa_pkg::grain_type    rd_data
);
   import ssa_pkg::*;

   grain_type mem [NUM_GRAINS];
   grain_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (link_req.wr_en) begin
         mem[link_req.wr_addr] <= link_req.wr_data;
      end
      if (link_req.rd_en) begin
         rd_data_ff <= mem[link_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/ssa_ctrl.sv
// ssa_ctrl: request decode, list heads, chunk tags and the alloc/free/carve sequencer
// depends on ssa_pkg and ssa_chan_if

module ssa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   ssa_req_if.sink               req_chan,
   input  ssa_pkg::grain_type    link_rd_data,
   input  logic                  rsp_free,
   output ssa_pkg::link_req_type link_req,
   output ssa_pkg::rsp_load_type rsp_load
);
   import ssa_pkg::*;

   state_type               state_ff, state_in;
   grain_type               heads_ff [NUM_CLASSES];
   logic [CLASS_W-1:0]      tags_ff [NUM_CHUNKS];
   logic [CHUNK_W:0]        used_ff, used_in;
   opcode_type              op_ff;
   logic                    oversize_ff;
   logic                    free_in_pool_ff;
   logic [CLS_IDX_W-1:0]    cls_ff;
   grain_type               head_ff;
   grain_type               grain_ff;
   logic [CHUNK_W-1:0]      chunk_ff, chunk_in;
   logic [OFF_W-1:0]        off_ff, off_in;

   logic                    accept;
   logic [BYTES_W:0]        total;
   logic [BYTES_W:0]        grains_total;
   logic                    oversize;
   logic [CLS_IDX_W-1:0]    alloc_cls;
   logic [ADDR_W-1:0]       chunk_num;
   logic                    free_in_pool;
   logic [CLS_IDX_W-1:0]    free_cls;
   logic [CLS_IDX_W-1:0]    sel_cls;
   logic [OFF_W-1:0]        step;
   logic                    no_chunk;
   logic                    carve_fits;
   grain_type               carve_grain;

   logic                    heads_we;
   logic [CLS_IDX_W-1:0]    heads_idx;
   grain_type               heads_wd;
   logic                    tag_we;

   // request decode
   always_comb begin
      total        = {1'b0, req_chan.request_bytes} + (BYTES_W+1)'(HEADER_BYTES);
      oversize     = total > (BYTES_W+1)'(LARGEST_BYTES);
      grains_total = (total + (BYTES_W+1)'(GRAIN_BYTES - 1)) >> GRAIN_SHIFT;
      alloc_cls    = CLS_IDX_W'(grains_total - (BYTES_W+1)'(1));
      chunk_num    = req_chan.block_address >> CHUNK_SHIFT;
      free_in_pool = chunk_num < ADDR_W'(used_ff);
      free_cls     = free_in_pool
                   ? CLS_IDX_W'(tags_ff[CHUNK_W'(chunk_num)]) : '0;
      sel_cls      = (req_chan.opcode == OP_FREE) ? free_cls
                   : (oversize ? '0 : alloc_cls);
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   assign step        = OFF_W'(cls_ff) + OFF_W'(1);
   assign no_chunk    = (used_ff == (CHUNK_W+1)'(NUM_CHUNKS))
                     || (step > OFF_W'(MAX_FIT_STEP));
   assign carve_fits  = (off_ff + step) <= OFF_W'(CHUNK_GRAINS);
   assign carve_grain = {chunk_ff, off_ff[CIDX_W-1:0]};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (rsp_free) begin
               if (!oversize_ff && op_ff == OP_ALLOC && head_ff == '0 && !no_chunk) begin
                  state_in = S_CARVE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CARVE: begin
            if (!carve_fits && rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      link_req         = '0;
      link_req.rd_en   = accept;
      link_req.rd_addr = heads_ff[sel_cls];
      rsp_load         = '0;
      heads_we         = 1'b0;
      heads_idx        = cls_ff;
      heads_wd         = '0;
      tag_we           = 1'b0;
      used_in          = used_ff;
      chunk_in         = chunk_ff;
      off_in           = off_ff;
      case (state_ff)
         S_EXEC: begin
            if (rsp_free) begin
               if (oversize_ff) begin
                  rsp_load.load   = 1'b1;
                  rsp_load.status = ST_OVERSIZE;
               end else if (op_ff == OP_FREE) begin
                  rsp_load.load = 1'b1;
                  rsp_load.cls  = CLASS_W'(cls_ff);
                  if (free_in_pool_ff && grain_ff != '0) begin
                     link_req.wr_en   = 1'b1;
                     link_req.wr_addr = grain_ff;
                     link_req.wr_data = head_ff;
                     heads_we         = 1'b1;
                     heads_wd         = grain_ff;
                  end
               end else if (head_ff != '0) begin
                  // pop: head moves to its link
                  rsp_load.load = 1'b1;
                  rsp_load.addr = ADDR_W'({head_ff, {GRAIN_SHIFT{1'b0}}});
                  rsp_load.cls  = CLASS_W'(cls_ff);
                  heads_we      = 1'b1;
                  heads_wd      = link_rd_data;
               end else if (no_chunk) begin
                  rsp_load.load   = 1'b1;
                  rsp_load.status = ST_EXHAUSTED;
                  rsp_load.cls    = CLASS_W'(cls_ff);
               end else begin
                  // fresh chunk: tag it and start the carve past block zero
                  tag_we   = 1'b1;
                  chunk_in = CHUNK_W'(used_ff);
                  used_in  = used_ff + (CHUNK_W+1)'(1);
                  off_in   = OFF_W'(1) + step;
               end
            end
         end
         S_CARVE: begin
            if (carve_fits) begin
               link_req.wr_en   = 1'b1;
               link_req.wr_addr = carve_grain;
               link_req.wr_data = heads_ff[cls_ff];
               heads_we         = 1'b1;
               heads_wd         = carve_grain;
               off_in           = off_ff + step;
            end else if (rsp_free) begin
               rsp_load.load = 1'b1;
               rsp_load.addr = ADDR_W'({chunk_ff, CIDX_W'(1), {GRAIN_SHIFT{1'b0}}});
               rsp_load.cls  = CLASS_W'(cls_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            heads_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         if (heads_we) begin
            heads_ff[heads_idx] <= heads_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      chunk_ff <= chunk_in;
      off_ff   <= off_in;
      if (tag_we) begin
         tags_ff[CHUNK_W'(used_ff)] <= CLASS_W'(cls_ff);
      end
      if (accept) begin
         op_ff           <= req_chan.opcode;
         oversize_ff     <= (req_chan.opcode == OP_ALLOC) && oversize;
         free_in_pool_ff <= free_in_pool;
         cls_ff          <= sel_cls;
         head_ff         <= heads_ff[sel_cls];
         grain_ff        <= GRAIN_W'(req_chan.block_address >> GRAIN_SHIFT);
      end
   end

endmodule

### rtl/core/segregated_slab_allocator.sv
// segregated_slab_allocator: top level, sequencer plus link memory plus response register
// depends on ssa_pkg, ssa_chan_if, ssa_link_ram, ssa_ctrl
//
//   channel    | dir | handshake    | word
//   req_chan   | in  | valid/ready  | opcode, request_bytes, block_address
//   rsp_chan   | out | valid/ready  | status, granted_address, size_class
//
// pop, free, error: accept with link read, then finish
// alloc on an empty list: n blocks pushed from the new chunk
//   (accept, tag the chunk, one link memory write per block, then the response)
//   n is up to about 4k for the smallest class
// reset clears list heads, chunk count and state; link memory and tags need none
// a waiting response word holds the sequencer in its final step, input stays
//   closed until the current word has moved into the response register

module segregated_slab_allocator (
   input  logic     clock,
   input  logic     reset,
   ssa_req_if.sink  req_chan,
   ssa_rsp_if.source rsp_chan
);
   import ssa_pkg::*;

   link_req_type link_req;
   grain_type    link_rd_data;
   rsp_load_type rsp_load;
   logic         rsp_free;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   logic [CLASS_W-1:0] rsp_cls_ff;

   // response register slot is free when empty or being drained
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   ssa_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .link_rd_data (link_rd_data),
      .rsp_free     (rsp_free),
      .link_req     (link_req),
      .rsp_load     (rsp_load)
   );

   ssa_link_ram u_link_ram (
      .clock    (clock),
      .link_req (link_req),
      .rd_data  (link_rd_data)
   );

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (rsp_load.load) begin
         rsp_status_ff <= rsp_load.status;
         rsp_addr_ff   <= rsp_load.addr;
         rsp_cls_ff    <= rsp_load.cls;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.granted_address = rsp_addr_ff;
   assign rsp_chan.size_class      = rsp_cls_ff;

endmodule

### rtl/core/ssa_checker.sv
// ssa_checker: port-level checks on the allocator's response words, with its bind
// depends on ssa_pkg and segregated_slab_allocator

module ssa_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input ssa_pkg::status_type         status,
   input logic [ssa_pkg::ADDR_W-1:0]  granted,
   input logic [ssa_pkg::CLASS_W-1:0] cls
);
   import ssa_pkg::*;

   // a stalled response word stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // errors never grant an address
   a_err_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != ST_OK |-> granted == '0)
      else $error("error word carries an address");

   // oversize reports class zero
   a_oversize_cls: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_OVERSIZE |-> cls == '0)
      else $error("oversize word carries a class");

   // granted blocks are grain aligned
   a_grant_align: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_OK |-> granted[GRAIN_SHIFT-1:0] == '0)
      else $error("granted address not grain aligned");

endmodule

bind segregated_slab_allocator ssa_checker u_ssa_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .status    (rsp_chan.status),
   .granted   (rsp_chan.granted_address),
   .cls       (rsp_chan.size_class)
);
